>>> design/vnt_pkg.sv
`default_nettype none
// ============================================================================
// vnt_pkg
// Shared types, constants and command codes of the von Neumann trend detector.
// ============================================================================
package vnt_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int MAX_SERIES_DEF  = 256;

    localparam int SAMPLE_W   = 24;
    localparam int RATIO_W    = 19;
    localparam int THR_W      = 16;
    localparam int FRAC_BITS  = 16;
    localparam int MUL_W      = 32;
    localparam int DIV_STEPS  = RATIO_W + 1;
    localparam int NUM_THR    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = THR_W;

    localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

    localparam int MIN_RATIO_COUNT = 4;
    localparam int MAX_JUDGE_COUNT = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_THR_FOUR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_FIVE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_SIX   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_SEVEN = 2'd3;

    localparam logic [THR_W-1:0] THR_FOUR_RST  = 16'd51151;
    localparam logic [THR_W-1:0] THR_FIVE_RST  = 16'd53766;
    localparam logic [THR_W-1:0] THR_SIX_RST   = 16'd58340;
    localparam logic [THR_W-1:0] THR_SEVEN_RST = 16'd61335;

    localparam logic [2:0] MUL_XX    = 3'd0;
    localparam logic [2:0] MUL_DD    = 3'd1;
    localparam logic [2:0] MUL_ND_LO = 3'd2;
    localparam logic [2:0] MUL_ND_HI = 3'd3;
    localparam logic [2:0] MUL_NQ_LO = 3'd4;
    localparam logic [2:0] MUL_NQ_HI = 3'd5;
    localparam logic [2:0] MUL_SS    = 3'd6;

    localparam logic [2:0] ACC_NONE    = 3'd0;
    localparam logic [2:0] ACC_SUMSQ   = 3'd1;
    localparam logic [2:0] ACC_UPDATE  = 3'd2;
    localparam logic [2:0] ACC_NUM_LO  = 3'd3;
    localparam logic [2:0] ACC_NUM_HI  = 3'd4;
    localparam logic [2:0] ACC_DEN_LO  = 3'd5;
    localparam logic [2:0] ACC_DEN_HI  = 3'd6;
    localparam logic [2:0] ACC_DEN_SUB = 3'd7;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                first;
    } t_in_beat;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio_q16;
        logic               ratio_valid;
        logic               judged;
        logic               trend;
    } t_out_beat;

    typedef struct packed {
        logic       load;
        logic [2:0] mul_sel;
        logic [2:0] acc_op;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

>>> design/vnt_datapath.sv
`default_nettype none
// ============================================================================
// vnt_datapath
// Series accumulators, shared 32x32 multiplier, restoring divider, threshold
// registers and the result register.
// ============================================================================
module vnt_datapath #(
    parameter int SAMPLE_BITS = vnt_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_SERIES  = vnt_pkg::MAX_SERIES_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  vnt_pkg::t_in_beat                i_in_data,
    input  vnt_pkg::t_dp_cmd                 i_cmd,
    output vnt_pkg::t_dp_status              o_status,
    input  wire                              i_cfg_we,
    input  wire [vnt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [vnt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output vnt_pkg::t_out_beat               o_out_data
);

    localparam int MW     = vnt_pkg::MUL_W;
    localparam int PW     = 2 * MW;
    localparam int CNT_W  = $clog2(MAX_SERIES + 1);
    localparam int LOG_W  = $clog2(MAX_SERIES);
    localparam int SUM_W  = SAMPLE_BITS + LOG_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS + LOG_W;
    localparam int WIDE_W = CNT_W + SQ_W;
    localparam int R_W    = WIDE_W + vnt_pkg::FRAC_BITS;
    localparam int DS     = vnt_pkg::DIV_STEPS;
    localparam int DV_W   = WIDE_W + DS - 1;
    localparam int RW     = vnt_pkg::RATIO_W;
    localparam int TW     = vnt_pkg::THR_W;
    localparam int TIDX_W = $clog2(vnt_pkg::NUM_THR);

    logic [SAMPLE_BITS-1:0] r_x;
    logic [SAMPLE_BITS-1:0] r_prev;
    logic [CNT_W-1:0]       r_cnt;
    logic [SUM_W-1:0]       r_sum;
    logic [SQ_W-1:0]        r_sumsq;
    logic [SQ_W-1:0]        r_dsq;
    logic [PW-1:0]          r_prod;
    logic [WIDE_W-1:0]      r_num;
    logic [WIDE_W-1:0]      r_den;
    logic [R_W-1:0]         r_rem;
    logic [DV_W-1:0]        r_dv;
    logic [DS-1:0]          r_quo;
    logic [TW-1:0]          r_thr [vnt_pkg::NUM_THR];
    logic                   r_out_valid;
    vnt_pkg::t_out_beat     r_out;

    logic [SAMPLE_BITS-1:0] w_diff;
    logic [PW-1:0]          w_dsq64;
    logic [PW-1:0]          w_sumsq64;
    logic [MW-1:0]          w_mul_a;
    logic [MW-1:0]          w_mul_b;
    logic                   w_take;
    logic                   w_ge;
    logic                   w_ratio_ok;
    logic                   w_judged;
    logic [TIDX_W-1:0]      w_thr_idx;
    logic [RW-1:0]          w_ratio;
    vnt_pkg::t_out_beat     w_out;

    assign w_diff    = (r_x >= r_prev) ? (r_x - r_prev) : (r_prev - r_x);
    assign w_dsq64   = PW'(r_dsq);
    assign w_sumsq64 = PW'(r_sumsq);
    assign w_take    = (r_cnt < CNT_W'(MAX_SERIES));
    assign w_ge      = (DV_W'(r_rem) >= r_dv);

    always_comb begin
        w_mul_a = MW'(r_cnt);
        w_mul_b = w_dsq64[MW-1:0];
        case (i_cmd.mul_sel)
            vnt_pkg::MUL_XX: begin
                w_mul_a = MW'(r_x);
                w_mul_b = MW'(r_x);
            end
            vnt_pkg::MUL_DD: begin
                w_mul_a = MW'(w_diff);
                w_mul_b = MW'(w_diff);
            end
            vnt_pkg::MUL_ND_LO: w_mul_b = w_dsq64[MW-1:0];
            vnt_pkg::MUL_ND_HI: w_mul_b = w_dsq64[PW-1:MW];
            vnt_pkg::MUL_NQ_LO: w_mul_b = w_sumsq64[MW-1:0];
            vnt_pkg::MUL_NQ_HI: w_mul_b = w_sumsq64[PW-1:MW];
            vnt_pkg::MUL_SS: begin
                w_mul_a = MW'(r_sum);
                w_mul_b = MW'(r_sum);
            end
            default: begin
                w_mul_a = MW'(r_cnt);
                w_mul_b = w_dsq64[MW-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (i_cmd.load) begin
            r_x <= i_in_data.sample[SAMPLE_BITS-1:0];
        end
        case (i_cmd.acc_op)
            vnt_pkg::ACC_NUM_LO:  r_num <= WIDE_W'(r_prod);
            vnt_pkg::ACC_NUM_HI:  r_num <= r_num + (WIDE_W'(r_prod) << MW);
            vnt_pkg::ACC_DEN_LO:  r_den <= WIDE_W'(r_prod);
            vnt_pkg::ACC_DEN_HI:  r_den <= r_den + (WIDE_W'(r_prod) << MW);
            vnt_pkg::ACC_DEN_SUB: r_den <= r_den - WIDE_W'(r_prod);
            default: begin
                r_num <= r_num;
            end
        endcase
        if (i_cmd.div_init) begin
            r_rem <= R_W'(r_num) << vnt_pkg::FRAC_BITS;
            r_dv  <= DV_W'(r_den) << (DS - 1);
        end else if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= r_rem - R_W'(r_dv);
            end
            r_dv  <= r_dv >> 1;
            r_quo <= {r_quo[DS-2:0], w_ge};
        end
        if (i_cmd.out_load) begin
            r_out <= w_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_dsq   <= '0;
            r_prev  <= '0;
        end else if (i_cmd.load && i_in_data.first) begin
            r_cnt   <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_dsq   <= '0;
            r_prev  <= '0;
        end else if (i_cmd.acc_op == vnt_pkg::ACC_SUMSQ) begin
            if (w_take) begin
                r_sumsq <= r_sumsq + SQ_W'(r_prod);
            end
        end else if (i_cmd.acc_op == vnt_pkg::ACC_UPDATE) begin
            if (w_take) begin
                if (r_cnt != '0) begin
                    r_dsq <= r_dsq + SQ_W'(r_prod);
                end
                r_sum  <= r_sum + SUM_W'(r_x);
                r_prev <= r_x;
                r_cnt  <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr[vnt_pkg::CFG_THR_FOUR]  <= vnt_pkg::THR_FOUR_RST;
            r_thr[vnt_pkg::CFG_THR_FIVE]  <= vnt_pkg::THR_FIVE_RST;
            r_thr[vnt_pkg::CFG_THR_SIX]   <= vnt_pkg::THR_SIX_RST;
            r_thr[vnt_pkg::CFG_THR_SEVEN] <= vnt_pkg::THR_SEVEN_RST;
        end else if (i_cfg_we) begin
            r_thr[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        w_ratio_ok = (r_cnt >= CNT_W'(vnt_pkg::MIN_RATIO_COUNT));
        w_judged   = w_ratio_ok && (r_cnt <= CNT_W'(vnt_pkg::MAX_JUDGE_COUNT));
        w_thr_idx  = TIDX_W'(r_cnt - CNT_W'(vnt_pkg::MIN_RATIO_COUNT));
        w_ratio    = r_quo[DS-1] ? vnt_pkg::RATIO_MAX : r_quo[RW-1:0];
        w_out.ratio_q16   = w_ratio_ok ? w_ratio : '0;
        w_out.ratio_valid = w_ratio_ok;
        w_out.judged      = w_judged;
        w_out.trend       = w_judged && (w_ratio <= RW'(r_thr[w_thr_idx]));
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule
`default_nettype wire

>>> design/vnt_controller.sv
`default_nettype none
// ============================================================================
// vnt_controller
// Sequencer that steps the datapath through update, products, division and
// result hand-off for one beat at a time.
// ============================================================================
module vnt_controller (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  vnt_pkg::t_dp_status  i_status,
    output vnt_pkg::t_dp_cmd     o_cmd
);

    localparam int STEP_W = $clog2(vnt_pkg::DIV_STEPS);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_DD   = 4'd2;
    localparam logic [3:0] ST_UPD  = 4'd3;
    localparam logic [3:0] ST_ND0  = 4'd4;
    localparam logic [3:0] ST_ND1  = 4'd5;
    localparam logic [3:0] ST_NQ0  = 4'd6;
    localparam logic [3:0] ST_NQ1  = 4'd7;
    localparam logic [3:0] ST_SS   = 4'd8;
    localparam logic [3:0] ST_DEN  = 4'd9;
    localparam logic [3:0] ST_DIVI = 4'd10;
    localparam logic [3:0] ST_DIV  = 4'd11;
    localparam logic [3:0] ST_OUT  = 4'd12;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    vnt_pkg::t_dp_cmd  w_cmd;

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        w_cmd          = '0;
        w_cmd.mul_sel  = vnt_pkg::MUL_XX;
        w_cmd.acc_op   = vnt_pkg::ACC_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = ST_SQ;
                end
            end
            ST_SQ: begin
                w_cmd.mul_sel = vnt_pkg::MUL_XX;
                n_state       = ST_DD;
            end
            ST_DD: begin
                w_cmd.mul_sel = vnt_pkg::MUL_DD;
                w_cmd.acc_op  = vnt_pkg::ACC_SUMSQ;
                n_state       = ST_UPD;
            end
            ST_UPD: begin
                w_cmd.acc_op = vnt_pkg::ACC_UPDATE;
                n_state      = ST_ND0;
            end
            ST_ND0: begin
                w_cmd.mul_sel = vnt_pkg::MUL_ND_LO;
                n_state       = ST_ND1;
            end
            ST_ND1: begin
                w_cmd.mul_sel = vnt_pkg::MUL_ND_HI;
                w_cmd.acc_op  = vnt_pkg::ACC_NUM_LO;
                n_state       = ST_NQ0;
            end
            ST_NQ0: begin
                w_cmd.mul_sel = vnt_pkg::MUL_NQ_LO;
                w_cmd.acc_op  = vnt_pkg::ACC_NUM_HI;
                n_state       = ST_NQ1;
            end
            ST_NQ1: begin
                w_cmd.mul_sel = vnt_pkg::MUL_NQ_HI;
                w_cmd.acc_op  = vnt_pkg::ACC_DEN_LO;
                n_state       = ST_SS;
            end
            ST_SS: begin
                w_cmd.mul_sel = vnt_pkg::MUL_SS;
                w_cmd.acc_op  = vnt_pkg::ACC_DEN_HI;
                n_state       = ST_DEN;
            end
            ST_DEN: begin
                w_cmd.acc_op = vnt_pkg::ACC_DEN_SUB;
                n_state      = ST_DIVI;
            end
            ST_DIVI: begin
                w_cmd.div_init = 1'b1;
                n_step         = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                w_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == STEP_W'(vnt_pkg::DIV_STEPS - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_cmd      = w_cmd;

endmodule
`default_nettype wire

>>> design/von_neumann_trend_detector.sv
`default_nettype none
// ============================================================================
// von_neumann_trend_detector
// Running von Neumann ratio over a series of samples with a trend judgment
// for short series.
// ============================================================================
// Each accepted beat is worked through to its result before the block
// accepts the next beat, once the previous result has been taken; the work
// is seven passes through one shared 32x32 multiplier and a 20-step
// restoring divider that yields the saturated Q3.16 ratio. A result
// waiting in the output register does not hold off the next beat's work.
module von_neumann_trend_detector #(
    parameter int SAMPLE_BITS = vnt_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_SERIES  = vnt_pkg::MAX_SERIES_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  vnt_pkg::t_in_beat                i_in_data,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output vnt_pkg::t_out_beat               o_out_data,
    input  wire                              i_cfg_we,
    input  wire [vnt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [vnt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    vnt_pkg::t_dp_cmd    w_cmd;
    vnt_pkg::t_dp_status w_status;

    vnt_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    vnt_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_SERIES  (MAX_SERIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

>>> design/vnt_checker.sv
`default_nettype none
// ============================================================================
// vnt_checker
// Port-level checks of the trend detector, bound to the top level.
// ============================================================================
module vnt_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    input  wire                              o_in_stall,
    input  wire                              o_out_valid,
    input  wire                              i_out_stall,
    input  vnt_pkg::t_out_beat               o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("Stalled result beat changed or vanished.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Input beat accepted while the previous one is in work.");

    a_short_series: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.ratio_valid |->
            o_out_data.ratio_q16 == '0 && !o_out_data.judged)
        else $error("Short series result carries a ratio or a judgment.");

    a_trend_judged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.trend |->
            o_out_data.judged && o_out_data.ratio_valid &&
            o_out_data.ratio_q16[vnt_pkg::RATIO_W-1:vnt_pkg::THR_W] == '0)
        else $error("Trend flagged without a judgment or above any threshold.");

endmodule

bind von_neumann_trend_detector vnt_checker u_vnt_checker (.*);
`default_nettype wire
